// ===== hdl/jss_pkg.sv =====
package jss_pkg;

    localparam int DATA_W     = 32;
    localparam int HSQ_W      = 32;
    localparam int DIFF_W     = 63;
    localparam int ROW_W      = 10;
    localparam int COL_CFG_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 96;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HSQ  = 2'd2;

    localparam logic [ROW_W-1:0]     ROWS_RST = 10'd1022;
    localparam logic [COL_CFG_W-1:0] COLS_RST = 10'd1022;
    localparam logic [HSQ_W-1:0]     HSQ_RST  = 32'd4096;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_SUM   = 8'b0001_0000,
        ST_DIF   = 8'b0010_0000,
        ST_SQR   = 8'b0100_0000,
        ST_ACC   = 8'b1000_0000
    } jss_state_t;

    typedef struct packed {
        logic accept;      // input word taken, row store reads issued
        logic load_ops;    // capture stencil operands, shift window
        logic we;          // row store write
        logic wr_zero;     // write zero (clearing pass)
        logic acc_update;  // add squared difference
        logic acc_clear;   // end of grid
        logic out_load;    // load result register
        logic last;        // final interior point
    } jss_cmd_t;

endpackage

// ===== hdl/jss_ram.sv =====
module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/jss_ctrl.sv =====
module jss_ctrl
    import jss_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    localparam int ADDR_W = $clog2(MAX_COLS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  out_busy,
    output jss_cmd_t              cmd,
    output logic [ADDR_W-1:0]     rd_col,
    output logic [ADDR_W-1:0]     rd_prev,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [HSQ_W-1:0]      h_squared
);

    localparam int CMP_W = ((ADDR_W > COL_CFG_W) ? ADDR_W : COL_CFG_W) + 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_COLS - 1);

    jss_state_t state_reg, state_next;

    logic [ROW_W-1:0]     rows_reg;
    logic [COL_CFG_W-1:0] cols_reg;
    logic [HSQ_W-1:0]     hsq_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W:0]    row_reg, row_next;
    logic [ADDR_W-1:0] cur_col_reg;
    logic              has_prev_reg, row_end_reg, grid_end_reg, emit_reg, last_reg;

    logic [CMP_W-1:0] cols_min, cols_eff, last_col, col_ext;
    logic [ROW_W:0]   last_row, row_ext;
    logic             row_end, grid_end, emit, last_pt;

    assign cfg_ready = 1'b1;
    assign h_squared = hsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RST;
            cols_reg <= COLS_RST;
            hsq_reg  <= HSQ_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data[ROW_W-1:0];
                CFG_COLS: cols_reg <= cfg_data[COL_CFG_W-1:0];
                CFG_HSQ:  hsq_reg  <= cfg_data[HSQ_W-1:0];
                default: ;
            endcase
        end
    end

    // grid geometry: zero acts as one, columns clamp to MAX_COLS - 2
    always_comb begin
        cols_min = (cols_reg == '0) ? CMP_W'(1) : CMP_W'(cols_reg);
        cols_eff = (cols_min > CMP_W'(MAX_COLS - 2)) ? CMP_W'(MAX_COLS - 2) : cols_min;
        last_col = cols_eff + CMP_W'(1);
        col_ext  = CMP_W'(col_reg);
        last_row = ((rows_reg == '0) ? (ROW_W + 1)'(1) : {1'b0, rows_reg}) + (ROW_W + 1)'(1);
        row_ext  = row_reg;
        row_end  = col_ext >= last_col;
        grid_end = row_end && (row_ext >= last_row);
        emit     = (row_ext >= (ROW_W + 1)'(2)) && (row_ext <= last_row)
                && (col_ext >= CMP_W'(2)) && (col_ext <= last_col);
        last_pt  = (row_ext == last_row) && (col_ext == last_col);
        if (row_end) begin
            col_next = '0;
            row_next = grid_end ? '0 : row_reg + (ROW_W + 1)'(1);
        end else begin
            col_next = col_reg + ADDR_W'(1);
            row_next = row_reg;
        end
    end

    assign rd_col  = col_reg;
    assign rd_prev = col_reg - ADDR_W'(1);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.last   = last_reg;
        s_tready   = 1'b0;
        wr_addr    = cur_col_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.we      = 1'b1;
                cmd.wr_zero = 1'b1;
                wr_addr     = clr_cnt_reg;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.load_ops = 1'b1;
                cmd.we       = has_prev_reg;
                wr_addr      = cur_col_reg - ADDR_W'(1);
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.we     = row_end_reg;
                state_next = ST_SUM;
            end
            ST_SUM: state_next = ST_DIF;
            ST_DIF: state_next = ST_SQR;
            ST_SQR: state_next = ST_ACC;
            ST_ACC: begin
                if (!(emit_reg && out_busy)) begin
                    cmd.acc_update = emit_reg;
                    cmd.out_load   = emit_reg;
                    cmd.acc_clear  = grid_end_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            cur_col_reg  <= '0;
            has_prev_reg <= 1'b0;
            row_end_reg  <= 1'b0;
            grid_end_reg <= 1'b0;
            emit_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.accept) begin
                cur_col_reg  <= col_reg;
                has_prev_reg <= col_reg != '0;
                row_end_reg  <= row_end;
                grid_end_reg <= grid_end;
                emit_reg     <= emit;
                last_reg     <= last_pt;
                col_reg      <= col_next;
                row_reg      <= row_next;
            end
        end
    end

endmodule

// ===== hdl/jss_dp.sv =====
module jss_dp
    import jss_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    localparam int ADDR_W = $clog2(MAX_COLS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  jss_cmd_t                 cmd,
    input  logic [ADDR_W-1:0]        rd_col,
    input  logic [ADDR_W-1:0]        rd_prev,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [HSQ_W-1:0]         h_squared,
    input  logic signed [DATA_W-1:0] old_value,
    input  logic signed [DATA_W-1:0] source_value,
    output logic signed [DATA_W-1:0] new_value,
    output logic [DIFF_W-1:0]        diff_sum,
    output logic                     last_point,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_busy
);

    logic signed [DATA_W-1:0] cur_reg, src_reg;
    logic signed [DATA_W-1:0] win0_reg, win1_reg, win2_reg, hold_reg;
    logic signed [DATA_W-1:0] up_reg, down_reg, left_reg, center_reg, scen_reg;
    logic [DATA_W-1:0] upper_rd, middle_rd, source_rd;
    logic [DATA_W-1:0] upper_wd, middle_wd, source_wd;

    logic signed [64:0] prod_full, rnd_val;
    logic signed [63:0] prod_reg;
    logic signed [33:0] nb_full, nb_reg;
    logic signed [32:0] p_val, n_full, d_val, d_abs;
    logic signed [34:0] v_val, v_rnd;
    logic signed [DATA_W-1:0] n_sat, n_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [63:0] sq_full, sq_reg;
    logic [64:0] total;
    logic [DIFF_W-1:0] acc_reg, acc_sum;
    logic valid_reg;

    // row stores: the window words of the previous column go back in
    assign upper_wd  = cmd.wr_zero ? '0 : win1_reg;
    assign middle_wd = cmd.wr_zero ? '0 : win2_reg;
    assign source_wd = cmd.wr_zero ? '0 : hold_reg;

    jss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_upper (
        .aclk(aclk), .we(cmd.we), .waddr(wr_addr), .wdata(upper_wd),
        .re(cmd.accept), .raddr(rd_prev), .rdata(upper_rd)
    );

    jss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_middle (
        .aclk(aclk), .we(cmd.we), .waddr(wr_addr), .wdata(middle_wd),
        .re(cmd.accept), .raddr(rd_col), .rdata(middle_rd)
    );

    jss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_source (
        .aclk(aclk), .we(cmd.we), .waddr(wr_addr), .wdata(source_wd),
        .re(cmd.accept), .raddr(rd_prev), .rdata(source_rd)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_reg <= old_value;
            src_reg <= source_value;
        end
        if (cmd.load_ops) begin
            up_reg     <= upper_rd;
            scen_reg   <= source_rd;
            left_reg   <= win0_reg;
            center_reg <= win1_reg;
            down_reg   <= win2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
            hold_reg <= '0;
        end else if (cmd.load_ops) begin
            win0_reg <= win1_reg;
            win1_reg <= middle_rd;
            win2_reg <= cur_reg;
            hold_reg <= src_reg;
        end
    end

    // arithmetic chain, one register per step
    assign prod_full = $signed({1'b0, h_squared}) * scen_reg;
    // once the window has shifted, win1 holds the right-hand neighbour
    assign nb_full   = up_reg + down_reg + left_reg + win1_reg;

    assign rnd_val = prod_reg + 65'sd2147483648;
    assign p_val   = rnd_val[64:32];
    assign v_val   = nb_reg - p_val;
    assign v_rnd   = v_val + 35'sd2;
    assign n_full  = v_rnd[34:2];

    always_comb begin
        if (n_full > 33'sd2147483647) begin
            n_sat = 32'sh7FFF_FFFF;
        end else if (n_full < -33'sd2147483648) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = n_full[DATA_W-1:0];
        end
    end

    assign d_val   = center_reg - n_reg;
    assign d_abs   = d_val[32] ? -d_val : d_val;
    assign sq_full = mag_reg * mag_reg;
    assign total   = {2'b00, acc_reg} + {1'b0, sq_reg};
    assign acc_sum = (total > {2'b00, DIFF_MAX}) ? DIFF_MAX : total[DIFF_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[63:0];
        nb_reg   <= nb_full;
        n_reg    <= n_sat;
        mag_reg  <= d_abs[DATA_W-1:0];
        sq_reg   <= sq_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (cmd.acc_update) begin
            acc_reg <= acc_sum;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            new_value  <= n_reg;
            diff_sum   <= acc_sum;
            last_point <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_busy  = valid_reg && !out_ready;

endmodule

// ===== hdl/jacobi_stencil_sweep.sv =====
// One Jacobi sweep of the 2D Poisson five-point stencil. The whole grid, halo
// border included, streams in raster order on the s_ side, (interior_rows + 2)
// rows of (interior_cols + 2) points, each word carrying the old value and the
// source term of one point (Q8.24). For every interior point one word leaves on
// the m_ side once the point below it has arrived: new = (up + down + left +
// right - h_squared * source) / 4, rounded half up and saturated, with the
// running saturating sum of squared old-new differences (Q15.48); tlast marks
// the final interior point, after which the sum restarts for the next grid.
// Halo points give no output word. A new word is taken only once the last is
// through: a sequencer walks each word through a row-store read, the write-back
// of one or two store columns and a multiply, round, difference and square
// chain, with a further wait only while a finished word sits untaken in the
// output register. After reset the row stores are zeroed over all MAX_COLS
// columns while s_tready stays low; the config port accepts writes at any time
// but should only be written while the block is idle.
module jacobi_stencil_sweep
    import jss_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel: 0 interior_rows, 1 interior_cols, 2 h_squared
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] old_value, [63:32] source_value
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] new_value, [94:32] diff_sum, [95] zero
    output logic                  m_tlast    // last_point
);

    localparam int ADDR_W = $clog2(MAX_COLS);

    jss_cmd_t           cmd;
    logic [ADDR_W-1:0]  rd_col, rd_prev, wr_addr;
    logic [HSQ_W-1:0]   h_squared;
    logic               out_busy;
    logic signed [DATA_W-1:0] new_value;
    logic [DIFF_W-1:0]  diff_sum;

    jss_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .out_busy  (out_busy),
        .cmd       (cmd),
        .rd_col    (rd_col),
        .rd_prev   (rd_prev),
        .wr_addr   (wr_addr),
        .h_squared (h_squared)
    );

    jss_dp #(.MAX_COLS(MAX_COLS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .rd_col       (rd_col),
        .rd_prev      (rd_prev),
        .wr_addr      (wr_addr),
        .h_squared    (h_squared),
        .old_value    (s_tdata[DATA_W-1:0]),
        .source_value (s_tdata[2*DATA_W-1:DATA_W]),
        .new_value    (new_value),
        .diff_sum     (diff_sum),
        .last_point   (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_busy     (out_busy)
    );

    assign m_tdata = {1'b0, diff_sum, new_value};

`ifndef SYNTHESIS
    // a row store write never coincides with issuing the reads of a new word
    a_no_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> !(s_tvalid && s_tready))
        else $error("row store write during input accept");

    // one word at a time: no accept straight after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous word in flight");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten while stalled");
`endif

endmodule
